// ===== sv/mppt_pkg.sv =====
// Package: shared constants, register indexes and result type of the mouse position tracker.
`default_nettype none
package mppt_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SumW    = PosW + 2;

  localparam logic [PosW-1:0] XLimitRst = 8'd80;
  localparam logic [PosW-1:0] YLimitRst = 8'd25;
  localparam logic [PosW-1:0] CurXRst   = 8'd40;
  localparam logic [PosW-1:0] CurYRst   = 8'd12;

  localparam logic [CfgIdxW-1:0] RegXLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegYLimit = 2'd1;

  typedef enum logic [2:0] {
    ByteFirst  = 3'b001,
    ByteSecond = 3'b010,
    ByteThird  = 3'b100
  } byte_idx_e;

  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic            packet_done;
  } result_t;

  function automatic logic [PosW-1:0] clamp_pos(input logic signed [SumW-1:0] v,
                                                input logic [PosW-1:0] limit);
    logic [PosW-1:0]        top;
    logic signed [SumW-1:0] top_ext;
    top     = (limit == '0) ? '0 : limit - PosW'(1);
    top_ext = $signed({2'b00, top});
    if (v < 0) begin
      return '0;
    end else if (v > top_ext) begin
      return top;
    end else begin
      return v[PosW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/mppt_core.sv =====
// Packet byte sequencer, position state and clamp logic of the mouse position tracker.
`default_nettype none
module mppt_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [mppt_pkg::ByteW-1:0]    byte_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mppt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mppt_pkg::PosW-1:0]     cfg_wdata_i,
  output mppt_pkg::result_t                  result_o
);

  mppt_pkg::byte_idx_e            idx_q, idx_d;
  logic [mppt_pkg::ByteW-1:0]     held_dx_q, held_dx_d;
  logic [mppt_pkg::PosW-1:0]      cur_x_q, cur_x_d;
  logic [mppt_pkg::PosW-1:0]      cur_y_q, cur_y_d;
  logic [mppt_pkg::PosW-1:0]      x_limit_q, x_limit_d;
  logic [mppt_pkg::PosW-1:0]      y_limit_q, y_limit_d;
  logic signed [mppt_pkg::SumW-1:0] sum_x, sum_y;
  logic                           done;

  assign sum_x = $signed({2'b00, cur_x_q}) + mppt_pkg::SumW'($signed(held_dx_q));
  assign sum_y = $signed({2'b00, cur_y_q}) - mppt_pkg::SumW'($signed(byte_i));

  always_comb begin
    idx_d     = idx_q;
    held_dx_d = held_dx_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    done      = 1'b0;
    if (step_i) begin
      case (idx_q)
        mppt_pkg::ByteSecond: begin
          held_dx_d = byte_i;
          idx_d     = mppt_pkg::ByteThird;
        end
        mppt_pkg::ByteThird: begin
          cur_x_d = mppt_pkg::clamp_pos(sum_x, x_limit_q);
          cur_y_d = mppt_pkg::clamp_pos(sum_y, y_limit_q);
          idx_d   = mppt_pkg::ByteFirst;
          done    = 1'b1;
        end
        default: begin
          idx_d = mppt_pkg::ByteSecond;
        end
      endcase
    end
  end

  always_comb begin
    x_limit_d = x_limit_q;
    y_limit_d = y_limit_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mppt_pkg::RegXLimit: x_limit_d = cfg_wdata_i;
        mppt_pkg::RegYLimit: y_limit_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= mppt_pkg::ByteFirst;
      held_dx_q <= '0;
      cur_x_q   <= mppt_pkg::CurXRst;
      cur_y_q   <= mppt_pkg::CurYRst;
      x_limit_q <= mppt_pkg::XLimitRst;
      y_limit_q <= mppt_pkg::YLimitRst;
    end else begin
      idx_q     <= idx_d;
      held_dx_q <= held_dx_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      x_limit_q <= x_limit_d;
      y_limit_q <= y_limit_d;
    end
  end

  assign result_o.pos_x       = cur_x_d;
  assign result_o.pos_y       = cur_y_d;
  assign result_o.packet_done = done;

endmodule
`default_nettype wire

// ===== sv/mouse_packet_position_tracker_unit.sv =====
// Top level of the mouse packet position tracker: input stage, core and result register.
//
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  rx_byte_i
// out      output     out_valid_o/ out_ready_i pos_x_o, pos_y_o, packet_done_o
// cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while the output is not stalled.
// The byte is registered, then the core updates position state as the byte
// moves into the result register. Reset puts the cursor at 40,12 with limits
// 80 and 25. A stalled output holds the result register, then the input stage.
`default_nettype none
module mouse_packet_position_tracker_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [mppt_pkg::ByteW-1:0]    rx_byte_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [mppt_pkg::PosW-1:0]     pos_x_o,
  output      logic [mppt_pkg::PosW-1:0]     pos_y_o,
  output      logic                          packet_done_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mppt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mppt_pkg::PosW-1:0]     cfg_wdata_i
);

  logic                       in_vld_q;
  logic [mppt_pkg::ByteW-1:0] in_byte_q;
  logic                       res_vld_q;
  mppt_pkg::result_t          res_q;
  mppt_pkg::result_t          core_res;
  logic                       advance;
  logic                       in_take;

  assign advance    = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  mppt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o   = res_vld_q;
  assign pos_x_o       = res_q.pos_x;
  assign pos_y_o       = res_q.pos_y;
  assign packet_done_o = res_q.packet_done;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for mouse_packet_position_tracker_unit: per-byte position prediction and result checks.
`timescale 1ns / 1ps
module tb;

  localparam logic [mppt_pkg::CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [mppt_pkg::CfgIdxW-1:0] RegSpare3 = 2'd3;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned LongHold   = 60;
  localparam int unsigned PhaseItems = 204;

  class position_scoreboard;
    mppt_pkg::result_t         expected_q[$];
    int unsigned               errors;
    logic [mppt_pkg::PosW-1:0] x_lim, y_lim, col, row, held_dx;
    mppt_pkg::byte_idx_e       slot;

    function new();
      errors  = 0;
      x_lim   = mppt_pkg::XLimitRst;
      y_lim   = mppt_pkg::YLimitRst;
      col     = mppt_pkg::CurXRst;
      row     = mppt_pkg::CurYRst;
      held_dx = '0;
      slot    = mppt_pkg::ByteFirst;
    endfunction

    function void set_reg(logic [mppt_pkg::CfgIdxW-1:0] idx, logic [mppt_pkg::PosW-1:0] val);
      case (idx)
        mppt_pkg::RegXLimit: x_lim = val;
        mppt_pkg::RegYLimit: y_lim = val;
        default: ;
      endcase
    endfunction

    static function logic [mppt_pkg::PosW-1:0] fit(int v, logic [mppt_pkg::PosW-1:0] lim);
      int top;
      top = (lim == 0) ? 0 : int'(lim) - 1;
      if (v < 0) return '0;
      if (v > top) return mppt_pkg::PosW'(top);
      return mppt_pkg::PosW'(v);
    endfunction

    function void note_byte(logic [mppt_pkg::ByteW-1:0] b);
      mppt_pkg::result_t r;
      r.packet_done = 1'b0;
      case (slot)
        mppt_pkg::ByteSecond: begin
          held_dx = b;
          slot    = mppt_pkg::ByteThird;
        end
        mppt_pkg::ByteThird: begin
          col = fit(int'(col) + int'($signed(held_dx)), x_lim);
          row = fit(int'(row) - int'($signed(b)), y_lim);
          slot = mppt_pkg::ByteFirst;
          r.packet_done = 1'b1;
        end
        default: slot = mppt_pkg::ByteSecond;
      endcase
      r.pos_x = col;
      r.pos_y = row;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [mppt_pkg::PosW-1:0] got, logic [mppt_pkg::PosW-1:0] want);
      errors++;
      $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
    endtask

    task check_result(logic [mppt_pkg::PosW-1:0] x, logic [mppt_pkg::PosW-1:0] y,
                      logic done);
      mppt_pkg::result_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result, pos_x", x, '0);
        return;
      end
      e = expected_q.pop_front();
      if (x !== e.pos_x) report("pos_x", x, e.pos_x);
      if (y !== e.pos_y) report("pos_y", y, e.pos_y);
      if (done !== e.packet_done) begin
        report("packet_done", mppt_pkg::PosW'(done), mppt_pkg::PosW'(e.packet_done));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [mppt_pkg::ByteW-1:0]   rx_byte = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [mppt_pkg::PosW-1:0]    pos_x, pos_y;
  logic                         packet_done;
  logic                         cfg_we = 1'b0;
  logic [mppt_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [mppt_pkg::PosW-1:0]    cfg_wdata = '0;

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned quiet = 0;

  position_scoreboard sb = new();

  mouse_packet_position_tracker_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .packet_done_o(packet_done),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QuietLimit) begin
      $display("mouse_packet_position_tracker_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [mppt_pkg::ByteW-1:0] mouse_byte();
    case ($urandom_range(0, 3))
      0, 1: return mppt_pkg::ByteW'($urandom_range(0, 255));
      2: return mppt_pkg::ByteW'($urandom_range(0, 14) - 7);
      default: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'h7F;
          2: return 8'h80;
          default: return 8'hFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_byte(logic [mppt_pkg::ByteW-1:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    sb.note_byte(b);
  endtask

  task automatic write_reg(logic [mppt_pkg::CfgIdxW-1:0] idx, logic [mppt_pkg::PosW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int gap;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (long_hold) begin
        gap = LongHold;
        long_hold = 1'b0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      sb.check_result(pos_x, pos_y, packet_done);
    end
  end

  initial begin
    logic [mppt_pkg::ByteW-1:0] opening[21];
    logic [mppt_pkg::PosW-1:0]  xs[8];
    logic [mppt_pkg::PosW-1:0]  ys[8];
    opening = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h80, 8'h7F, 8'h08, 8'h01, 8'hFF,
                8'h18, 8'hFF, 8'h01, 8'h28, 8'h7F, 8'h81, 8'h55, 8'h00, 8'h00,
                8'hAA, 8'h81, 8'h00};
    xs = '{8'd255, 8'd1, 8'd0, 8'd2, 8'd255, 8'd0, 8'd0, 8'd80};
    ys = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd1, 8'd0, 8'd0, 8'd25};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i]);
    repeat (PhaseItems - 4) send_byte(mouse_byte());

    for (int p = 0; p < 8; p++) begin
      drain();
      if (p == 5 || p == 6) begin
        xs[p] = mppt_pkg::PosW'($urandom_range(1, 254));
        ys[p] = mppt_pkg::PosW'($urandom_range(1, 254));
      end
      write_reg(mppt_pkg::RegXLimit, xs[p]);
      write_reg(mppt_pkg::RegYLimit, ys[p]);
      write_reg((p % 2 == 0) ? RegSpare2 : RegSpare3, mppt_pkg::PosW'($urandom_range(0, 255)));
      cfg_we <= 1'b0;
      tx_idle = (p % 2 == 0);
      rx_idle = (p % 3 != 0);
      if (p == 2) long_hold = 1'b1;
      repeat (PhaseItems) send_byte(mouse_byte());
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("mouse_packet_position_tracker_unit: match");
    end else begin
      $display("mouse_packet_position_tracker_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== mouse_packet_position_tracker_unit.f =====
sv/mppt_pkg.sv
sv/mppt_core.sv
sv/mouse_packet_position_tracker_unit.sv
bench/tb.sv
